// ----- rtl/stl_pkg.sv -----
// Shared types and constants for the shell token lexer.
// No dependencies; imported by every module of the block.
package stl_pkg;

   localparam int TOKEN_W = 13;   // width of token offsets on the result port
   localparam int SLOTS   = 3;    // most tokens one byte can produce

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DQ    = 8'h22;
   localparam logic [7:0] CHAR_SQ    = 8'h27;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_PIPE  = 8'h7C;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_DQUOTE  = 3'd2,
      MODE_SQUOTE  = 3'd3,
      MODE_GT      = 3'd4,
      MODE_LT      = 3'd5,
      MODE_DONE    = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      KIND_WORD    = 3'd0,
      KIND_PIPE    = 3'd1,
      KIND_IN      = 3'd2,
      KIND_OUT     = 3'd3,
      KIND_HEREDOC = 3'd4,
      KIND_APPEND  = 3'd5,
      KIND_EOL     = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [TOKEN_W-1:0] tok_start;
      logic [TOKEN_W-1:0] tok_end;
      logic               overflow;
   } token_type;

   // tokens produced by one byte, in order, with their count
   typedef struct packed {
      logic [1:0]            count;
      token_type [SLOTS-1:0] tok;
   } lex_out_type;

endpackage

// ----- rtl/stl_lex_core.sv -----
// Lexer state registers and per-byte token decode for the shell token lexer.
// Depends on stl_pkg.
module stl_lex_core import stl_pkg::*; #(
   parameter int LINE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  char_in,
   input  logic        line_end,
   output lex_out_type lex_out
);

   localparam int POS_W = $clog2(LINE_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_BYTES);

   mode_type           mode_ff, mode_in, mode_lex, bw_mode;
   logic [POS_W-1:0]   pos_ff, pos_in, nxt;
   logic [POS_W-1:0]   start_ff, start_in, start_lex;
   logic               ovf_ff, ovf_in, ovf_now;

   logic c_nul, c_space, c_pipe, c_gt, c_lt, c_dq, c_sq, c_op;
   logic use_bw, a_vld;
   kind_type a_kind;
   logic [POS_W-1:0] a_end;

   token_type [3:0] cand;
   logic [3:0]      cand_vld;
   logic [1:0]      n;

   assign c_nul   = (char_in == CHAR_NUL);
   assign c_space = (char_in inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]});
   assign c_pipe  = (char_in == CHAR_PIPE);
   assign c_gt    = (char_in == CHAR_GT);
   assign c_lt    = (char_in == CHAR_LT);
   assign c_dq    = (char_in == CHAR_DQ);
   assign c_sq    = (char_in == CHAR_SQ);
   assign c_op    = c_pipe | c_gt | c_lt;

   // offsets saturate at the line limit
   assign ovf_now = ovf_ff | (pos_ff == POS_LIMIT);
   assign nxt     = (pos_ff == POS_LIMIT) ? pos_ff : pos_ff + 1'b1;

   // mode entered when a byte is lexed from between tokens
   always_comb begin
      if (c_space)      bw_mode = MODE_BETWEEN;
      else if (c_nul)   bw_mode = MODE_DONE;
      else if (c_pipe)  bw_mode = MODE_BETWEEN;
      else if (c_gt)    bw_mode = MODE_GT;
      else if (c_lt)    bw_mode = MODE_LT;
      else if (c_dq)    bw_mode = MODE_DQUOTE;
      else if (c_sq)    bw_mode = MODE_SQUOTE;
      else              bw_mode = MODE_WORD;
   end

   // byte decode: closing token of the current mode, and whether the byte
   // is then lexed afresh
   always_comb begin
      mode_lex  = mode_ff;
      start_lex = start_ff;
      use_bw    = 1'b0;
      a_vld     = 1'b0;
      a_kind    = KIND_WORD;
      a_end     = pos_ff;
      case (mode_ff)
         MODE_BETWEEN: use_bw = 1'b1;
         MODE_WORD: begin
            if (c_nul || c_space || c_op) begin
               a_vld  = 1'b1;
               use_bw = 1'b1;
            end else if (c_dq) begin
               mode_lex = MODE_DQUOTE;
            end else if (c_sq) begin
               mode_lex = MODE_SQUOTE;
            end
         end
         MODE_DQUOTE: begin
            if (c_nul) begin
               a_vld  = 1'b1;
               use_bw = 1'b1;
            end else if (c_dq) begin
               mode_lex = MODE_WORD;
            end
         end
         MODE_SQUOTE: begin
            if (c_nul) begin
               a_vld  = 1'b1;
               use_bw = 1'b1;
            end else if (c_sq) begin
               mode_lex = MODE_WORD;
            end
         end
         MODE_GT: begin
            a_vld = 1'b1;
            if (c_gt) begin
               a_kind   = KIND_APPEND;
               a_end    = nxt;
               mode_lex = MODE_BETWEEN;
            end else begin
               a_kind = KIND_OUT;
               use_bw = 1'b1;
            end
         end
         MODE_LT: begin
            a_vld = 1'b1;
            if (c_lt) begin
               a_kind   = KIND_HEREDOC;
               a_end    = nxt;
               mode_lex = MODE_BETWEEN;
            end else begin
               a_kind = KIND_IN;
               use_bw = 1'b1;
            end
         end
         default: mode_lex = MODE_DONE;
      endcase
      if (use_bw) begin
         mode_lex = bw_mode;
         if (!c_space) start_lex = pos_ff;
      end
   end

   // next state: a final byte returns everything to reset values
   always_comb begin
      mode_in  = line_end ? MODE_BETWEEN : mode_lex;
      start_in = line_end ? '0 : start_lex;
      pos_in   = line_end ? '0 : nxt;
      ovf_in   = line_end ? 1'b0 : ovf_now;
   end

   // outputs: up to four candidate tokens, packed in order
   always_comb begin
      cand[0].kind      = a_kind;
      cand[0].tok_start = TOKEN_W'(start_ff);
      cand[0].tok_end   = TOKEN_W'(a_end);
      cand[0].overflow  = ovf_now;
      cand_vld[0]       = a_vld;

      cand[1].kind      = c_nul ? KIND_EOL : KIND_PIPE;
      cand[1].tok_start = TOKEN_W'(pos_ff);
      cand[1].tok_end   = c_nul ? TOKEN_W'(pos_ff) : TOKEN_W'(nxt);
      cand[1].overflow  = ovf_now;
      cand_vld[1]       = use_bw & (c_nul | c_pipe);

      // open token closed by the end of the line
      if (mode_lex == MODE_GT)      cand[2].kind = KIND_OUT;
      else if (mode_lex == MODE_LT) cand[2].kind = KIND_IN;
      else                          cand[2].kind = KIND_WORD;
      cand[2].tok_start = TOKEN_W'(start_lex);
      cand[2].tok_end   = TOKEN_W'(nxt);
      cand[2].overflow  = ovf_now;
      cand_vld[2]       = line_end & (mode_lex inside {MODE_WORD, MODE_DQUOTE, MODE_SQUOTE,
                                                       MODE_GT, MODE_LT});

      cand[3].kind      = KIND_EOL;
      cand[3].tok_start = TOKEN_W'(nxt);
      cand[3].tok_end   = TOKEN_W'(nxt);
      cand[3].overflow  = ovf_now;
      cand_vld[3]       = line_end & (mode_lex != MODE_DONE);

      lex_out = '0;
      n       = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_vld[i]) begin
            lex_out.tok[n] = cand[i];
            n = n + 1'b1;
         end
      end
      lex_out.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BETWEEN;
         pos_ff   <= '0;
         start_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- rtl/stl_rsp_buf.sv -----
// Result register for the shell token lexer: holds the tokens of one item
// and hands them out one per cycle while rsp_ready is high. Depends on stl_pkg.
module stl_rsp_buf import stl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  lex_out_type lex_out,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output token_type   rsp_tok,
   output logic        rsp_last,
   output logic        can_load
);

   token_type [SLOTS-1:0] tok_ff;
   logic [1:0]            left_ff, left_in;
   logic [1:0]            rd_ff, rd_in;
   logic                  fire;

   assign rsp_valid = (left_ff != 2'd0);
   assign rsp_tok   = tok_ff[rd_ff];
   assign rsp_last  = (left_ff == 2'd1);
   assign fire      = rsp_valid & rsp_ready;
   // free now, or freed by the last token leaving this cycle
   assign can_load  = (left_ff == 2'd0) | (rsp_last & rsp_ready);

   always_comb begin
      left_in = left_ff;
      rd_in   = rd_ff;
      if (load) begin
         left_in = lex_out.count;
         rd_in   = '0;
      end else if (fire) begin
         left_in = left_ff - 1'b1;
         rd_in   = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         rd_ff   <= '0;
      end else begin
         left_ff <= left_in;
         rd_ff   <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) tok_ff <= lex_out.tok;
   end

endmodule

// ----- rtl/shell_token_lexer.sv -----
// Top level of the shell token lexer: byte decode plus result register.
// Depends on stl_pkg, stl_lex_core and stl_rsp_buf.
//
// Streams a command line one byte per item and returns its tokens (word,
// pipe, redirects, heredoc, append, end of line) with start and exclusive
// end offsets. A byte is taken every cycle as long as the tokens of the
// previous byte are gone from the result register or the last of them
// leaves in the same cycle; tokens appear in the cycle after their byte.
// A byte with n tokens (0 to 3, usually 0 or 1) holds the result port
// until all n are taken; one byte per cycle is sustained while no byte
// gives more than one token and rsp_ready is high. A '>' or '<' is resolved
// one byte later, when the next byte shows whether it pairs up. Offsets
// saturate at LINE_BYTES and pos_overflow flags a line that ran past it.
module shell_token_lexer import stl_pkg::*; #(
   parameter int LINE_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_in,
   input  logic               req_line_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_token_kind,
   output logic [TOKEN_W-1:0] rsp_token_start,
   output logic [TOKEN_W-1:0] rsp_token_end,
   output logic               rsp_pos_overflow,
   output logic               rsp_last_result
);

   lex_out_type lex_out;
   token_type   rsp_tok;
   logic        can_load, step;

   assign req_ready = can_load;
   assign step      = req_valid & can_load;

   stl_lex_core #(
      .LINE_BYTES (LINE_BYTES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_in  (req_char_in),
      .line_end (req_line_end),
      .lex_out  (lex_out)
   );

   stl_rsp_buf u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .lex_out   (lex_out),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_tok   (rsp_tok),
      .rsp_last  (rsp_last_result),
      .can_load  (can_load)
   );

   assign rsp_token_kind   = rsp_tok.kind;
   assign rsp_token_start  = rsp_tok.tok_start;
   assign rsp_token_end    = rsp_tok.tok_end;
   assign rsp_pos_overflow = rsp_tok.overflow;

endmodule

// ----- rtl/stl_checker.sv -----
// Port-level checks for the shell token lexer, bound to the top level.
// Depends on stl_pkg.
module stl_checker import stl_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_char_in,
   input logic               req_line_end,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_token_kind,
   input logic [TOKEN_W-1:0] rsp_token_start,
   input logic [TOKEN_W-1:0] rsp_token_end,
   input logic               rsp_pos_overflow,
   input logic               rsp_last_result
);

   // a stalled token holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_token_start) && $stable(rsp_token_end)
         && $stable(rsp_last_result))
      else $error("result item changed while stalled");

   // no new item while tokens of the previous one are stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while results still pending");

   // end of line is empty and closes the item
   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_EOL |->
         rsp_token_start == rsp_token_end && rsp_last_result)
      else $error("end-of-line token malformed");

   // a pipe is one byte long below the position limit
   a_pipe_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_PIPE && !rsp_pos_overflow |->
         rsp_token_end == TOKEN_W'(rsp_token_start + 1'b1))
      else $error("pipe token length wrong");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind shell_token_lexer stl_checker u_checker (.*);
